FILE: sv/tie_pkg.sv
// shared types and constants for the trap and interrupt entry unit
`default_nettype none
package tie_pkg;

	// command codes
	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_SYNC_TRAP = 3'd1;
	localparam logic [2:0] CMD_WR_STATUS = 3'd2;
	localparam logic [2:0] CMD_WR_BASE   = 3'd3;
	localparam logic [2:0] CMD_RAISE_IPI = 3'd4;

	// interrupt levels of the internal sources
	localparam logic [3:0] LVL_IPI     = 4'd14;
	localparam logic [3:0] LVL_TIMER   = 4'd10;
	localparam logic [3:0] LVL_MAILBOX = 4'd8;
	localparam logic [3:0] LVL_NMI     = 4'd15;

	// trap types with special meaning
	localparam logic [7:0] TT_INTERRUPT_BASE = 8'h10;
	localparam logic [7:0] TT_MAILBOX        = 8'h18;
	localparam logic [7:0] TT_IPI            = 8'h1E;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [29:0] pc;
		logic [29:0] npc;
		logic [7:0]  trap_num;
		logic [31:0] cycle_count;
		logic        mailbox_valid;
		logic [3:0]  ext_level;
		logic        wr_enable_traps;
		logic        wr_supervisor;
		logic [3:0]  wr_level;
		logic [4:0]  wr_window;
		logic [19:0] wr_base;
	} tie_in_t;

	typedef struct packed {
		logic        took_trap;
		logic [7:0]  trap_type;
		logic [29:0] new_pc;
		logic [29:0] new_npc;
		logic [31:0] saved_pc;
		logic [31:0] saved_npc;
		logic [4:0]  window;
		logic        error_mode;
		logic        mailbox_ack;
	} tie_out_t;

	// architectural state of the core's trap logic
	typedef struct packed {
		logic [3:0]  pending_level;
		logic        traps_enabled;
		logic        supervisor;
		logic        prev_supervisor;
		logic [3:0]  proc_level;
		logic [4:0]  cur_window;
		logic [19:0] base_high;
		logic [7:0]  type_field;
		logic        ipi_waiting;
		logic        halted;
	} tie_state_t;

	localparam tie_state_t STATE_RESET = '{
		pending_level:   4'd0,
		traps_enabled:   1'b0,
		supervisor:      1'b1,
		prev_supervisor: 1'b0,
		proc_level:      4'd0,
		cur_window:      5'd0,
		base_high:       20'd0,
		type_field:      8'd0,
		ipi_waiting:     1'b0,
		halted:          1'b0
	};

endpackage
`default_nettype wire

FILE: sv/tie_step.sv
// combinational next state and result for one command
`default_nettype none
module tie_step #(
	parameter int WINDOW_COUNT = 8
) (
	input  tie_pkg::tie_state_t cur,
	input  tie_pkg::tie_in_t    item,
	input  logic [31:0]         tick_period,
	output tie_pkg::tie_state_t nxt,
	output tie_pkg::tie_out_t   res
);
	import tie_pkg::*;

	localparam logic [4:0] WIN_LAST  = 5'(WINDOW_COUNT - 1);
	localparam logic [5:0] WIN_COUNT = 6'(WINDOW_COUNT);

	logic [3:0]  lvl_ext;
	logic [3:0]  lvl_ipi;
	logic [3:0]  lvl_tmr;
	logic [3:0]  lvl_all;
	logic        timer_fire;
	logic        irq_take;
	logic        trap_req;
	logic [7:0]  trap_tt;
	logic [4:0]  win_dec;
	logic [29:0] vec;

	// raise pending level from the four sources
	assign timer_fire = (tick_period != 32'd0) &&
		((item.cycle_count & (tick_period - 32'd1)) == 32'd0);
	assign lvl_ext = (cur.pending_level < item.ext_level) ? item.ext_level
		: cur.pending_level;
	assign lvl_ipi = (lvl_ext < LVL_IPI && cur.ipi_waiting) ? LVL_IPI : lvl_ext;
	assign lvl_tmr = (lvl_ipi < LVL_TIMER && timer_fire) ? LVL_TIMER : lvl_ipi;
	assign lvl_all = (lvl_tmr < LVL_MAILBOX && item.mailbox_valid) ? LVL_MAILBOX
		: lvl_tmr;
	assign irq_take = cur.traps_enabled &&
		(lvl_all == LVL_NMI || lvl_all > cur.proc_level);

	// window decrement with wrap
	assign win_dec = (cur.cur_window != 5'd0) ? cur.cur_window - 5'd1 : WIN_LAST;

	always_comb begin
		nxt      = cur;
		trap_req = 1'b0;
		trap_tt  = item.trap_num;
		res      = '0;

		// command decode
		if (item.cmd == CMD_RAISE_IPI) begin
			nxt.ipi_waiting = 1'b1;
		end else if (!cur.halted) begin
			unique case (item.cmd)
				CMD_TICK: begin
					nxt.pending_level = lvl_all;
					if (irq_take) begin
						trap_req          = 1'b1;
						trap_tt           = TT_INTERRUPT_BASE + {4'd0, lvl_all};
						nxt.pending_level = 4'd0;
					end
				end
				CMD_SYNC_TRAP: begin
					trap_req = (item.trap_num != 8'd0);
				end
				CMD_WR_STATUS: begin
					if ({1'b0, item.wr_window} < WIN_COUNT) begin
						nxt.traps_enabled = item.wr_enable_traps;
						nxt.supervisor    = item.wr_supervisor;
						nxt.proc_level    = item.wr_level;
						nxt.cur_window    = item.wr_window;
					end
				end
				CMD_WR_BASE: begin
					nxt.base_high = item.wr_base;
				end
				default: begin
				end
			endcase
		end

		// trap vector from base and trap type
		vec = {cur.base_high, trap_tt, 2'b00};

		// trap entry, or error mode when traps are disabled
		if (trap_req) begin
			if (!cur.traps_enabled) begin
				nxt.halted = 1'b1;
			end else begin
				nxt.traps_enabled   = 1'b0;
				nxt.prev_supervisor = cur.supervisor;
				nxt.supervisor      = 1'b1;
				nxt.cur_window      = win_dec;
				nxt.type_field      = trap_tt;
				if (trap_tt == TT_IPI) begin
					nxt.ipi_waiting = 1'b0;
				end
				res.took_trap   = 1'b1;
				res.trap_type   = trap_tt;
				res.new_pc      = vec;
				res.new_npc     = vec + 30'd1;
				res.saved_pc    = {item.pc, 2'b00};
				res.saved_npc   = {item.npc, 2'b00};
				res.mailbox_ack = (trap_tt == TT_MAILBOX) && item.mailbox_valid;
			end
		end

		res.window     = nxt.cur_window;
		res.error_mode = nxt.halted;
	end

endmodule
`default_nettype wire

FILE: sv/trap_and_interrupt_entry_unit_top.sv
// top level of the trap and interrupt entry unit
// Trap and interrupt entry for one SPARC-style core. Each transfer on req is one
// command (tick, synchronous trap, status write, trap base write, inter-processor
// request) and yields exactly one transfer on rsp. The unit sustains one command
// per cycle while rsp is not stalled. A command passes through the input register
// and then the result register, which drives rsp and rsp_valid, with the trap state
// updated as a command moves from the first into the second. A stalled rsp holds
// req_ready low once both registers are occupied. The user must write tick_period
// through cfg_wr_en/cfg_wr_data only while the unit holds no command; the unit
// itself does not enforce this.
`default_nettype none
module trap_and_interrupt_entry_unit_top #(
	parameter int WINDOW_COUNT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  tie_pkg::tie_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output tie_pkg::tie_out_t rsp,
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data
);
	import tie_pkg::*;

	logic        item_valid_s1;
	tie_in_t     item_s1;
	logic        rsp_valid_s2;
	tie_out_t    rsp_s2;
	tie_state_t  state_q;
	tie_state_t  state_nxt;
	tie_out_t    res;
	logic [31:0] tick_period_q;
	logic        advance;

	assign advance   = item_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !item_valid_s1 || advance;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// timer period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= 32'd0;
		end else if (cfg_wr_en) begin
			tick_period_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			item_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	tie_step #(
		.WINDOW_COUNT(WINDOW_COUNT)
	) u_step (
		.cur        (state_q),
		.item       (item_s1),
		.tick_period(tick_period_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	// trap state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= STATE_RESET;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				rsp_valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_s2 <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= res;
		end
	end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for the trap and interrupt entry unit
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tie_pkg::*;

	localparam int WINDOWS = 8;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// scoreboard: tracks the trap state and queues the result due for each transfer
	class trap_entry_sb;
		tie_state_t  st;
		logic [31:0] tick_period;
		tie_out_t    trap_results[$];
		int unsigned failures;

		function new();
			st = STATE_RESET;
			tick_period = '0;
			failures = 0;
		endfunction

		// trap entry, or error mode when traps are off
		function void enter_trap(input logic [7:0] tt, input tie_in_t c, inout tie_out_t r);
			logic [29:0] vec;
			if (!st.traps_enabled) begin
				st.halted = 1'b1;
				return;
			end
			st.traps_enabled = 1'b0;
			st.prev_supervisor = st.supervisor;
			st.supervisor = 1'b1;
			st.cur_window = (st.cur_window != 5'd0) ? 5'(st.cur_window - 5'd1) : 5'(WINDOWS - 1);
			st.type_field = tt;
			if (tt == TT_IPI)
				st.ipi_waiting = 1'b0;
			vec = {st.base_high, tt, 2'b00};
			r.took_trap = 1'b1;
			r.trap_type = tt;
			r.new_pc = vec;
			r.new_npc = 30'(vec + 30'd1);
			r.saved_pc = {c.pc, 2'b00};
			r.saved_npc = {c.npc, 2'b00};
			r.mailbox_ack = (tt == TT_MAILBOX) && c.mailbox_valid;
		endfunction

		// accepted command: update state and queue its result
		function void note_command(input tie_in_t c);
			tie_out_t r;
			r = '0;
			if (c.cmd == CMD_RAISE_IPI) begin
				st.ipi_waiting = 1'b1;
			end else if (!st.halted) begin
				case (c.cmd)
					CMD_TICK: begin
						if (st.pending_level < c.ext_level)
							st.pending_level = c.ext_level;
						if (st.pending_level < LVL_IPI && st.ipi_waiting)
							st.pending_level = LVL_IPI;
						if (st.pending_level < LVL_TIMER && tick_period != 32'd0 &&
								(c.cycle_count & (tick_period - 32'd1)) == 32'd0)
							st.pending_level = LVL_TIMER;
						if (st.pending_level < LVL_MAILBOX && c.mailbox_valid)
							st.pending_level = LVL_MAILBOX;
						if (st.traps_enabled && (st.pending_level == LVL_NMI ||
								st.pending_level > st.proc_level)) begin
							enter_trap(TT_INTERRUPT_BASE + {4'd0, st.pending_level}, c, r);
							st.pending_level = 4'd0;
						end
					end
					CMD_SYNC_TRAP: begin
						if (c.trap_num != 8'd0)
							enter_trap(c.trap_num, c, r);
					end
					CMD_WR_STATUS: begin
						if (c.wr_window < WINDOWS) begin
							st.traps_enabled = c.wr_enable_traps;
							st.supervisor = c.wr_supervisor;
							st.proc_level = c.wr_level;
							st.cur_window = c.wr_window;
						end
					end
					CMD_WR_BASE: begin
						st.base_high = c.wr_base;
					end
					default: begin
					end
				endcase
			end
			r.window = st.cur_window;
			r.error_mode = st.halted;
			trap_results.push_back(r);
		endfunction

		function void cmp(input string name, input logic [31:0] want, input logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				failures++;
			end
		endfunction

		// result transfer: compare with the oldest queued result
		function void check_result(input tie_out_t got);
			tie_out_t want;
			if (trap_results.size() == 0) begin
				$error("result transfer with nothing outstanding");
				failures++;
				return;
			end
			want = trap_results.pop_front();
			cmp("took_trap", 32'(want.took_trap), 32'(got.took_trap));
			cmp("trap_type", 32'(want.trap_type), 32'(got.trap_type));
			cmp("new_pc", 32'(want.new_pc), 32'(got.new_pc));
			cmp("new_npc", 32'(want.new_npc), 32'(got.new_npc));
			cmp("saved_pc", want.saved_pc, got.saved_pc);
			cmp("saved_npc", want.saved_npc, got.saved_npc);
			cmp("window", 32'(want.window), 32'(got.window));
			cmp("error_mode", 32'(want.error_mode), 32'(got.error_mode));
			cmp("mailbox_ack", 32'(want.mailbox_ack), 32'(got.mailbox_ack));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	tie_in_t     req;
	logic        rsp_valid;
	logic        rsp_ready;
	tie_out_t    rsp;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	trap_entry_sb sb;
	int          idle_pct = 0;
	int          stall_pct = 0;
	bit          pressure_on = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned cycle_cnt = 0;

	trap_and_interrupt_entry_unit_top #(
		.WINDOW_COUNT(WINDOWS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, or long hold-offs under pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (pressure_on) begin
			hold_cnt <= (hold_cnt == 59) ? 0 : hold_cnt + 1;
			rsp_ready <= (hold_cnt >= 40);
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	// offer one command, with random idle cycles ahead of it
	task automatic send(input tie_in_t c);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		req <= c;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_command(c);
	endtask

	// timer period write, only once the unit has drained
	task automatic write_timer(input logic [31:0] period);
		while (sb.trap_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= period;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.tick_period = period;
	endtask

	function automatic tie_in_t quiet_cmd(input logic [2:0] op);
		tie_in_t c;
		c = '0;
		c.cmd = op;
		c.pc = 30'($urandom());
		c.npc = 30'($urandom());
		return c;
	endfunction

	// random command; unless halting is allowed, traps only fire with traps enabled
	function automatic tie_in_t rand_cmd(input bit allow_halt);
		tie_in_t c;
		int unsigned pick;
		c.pc = 30'($urandom());
		c.npc = 30'($urandom());
		c.cycle_count = $urandom() & (32'hFFFF_FFFF << $urandom_range(12));
		c.mailbox_valid = 1'($urandom());
		c.ext_level = ($urandom_range(1) == 0) ? 4'($urandom()) : 4'd0;
		c.wr_enable_traps = ($urandom_range(9) != 0);
		c.wr_supervisor = 1'($urandom());
		c.wr_level = 4'($urandom());
		c.wr_window = ($urandom_range(7) == 0) ? 5'($urandom()) : 5'($urandom_range(WINDOWS - 1));
		c.wr_base = 20'($urandom());
		case ($urandom_range(9))
			0: c.trap_num = TT_MAILBOX;
			1: c.trap_num = TT_IPI;
			2: c.trap_num = 8'd0;
			default: c.trap_num = 8'($urandom());
		endcase
		pick = $urandom_range(99);
		if (pick < 38)
			c.cmd = CMD_TICK;
		else if (pick < 60)
			c.cmd = CMD_SYNC_TRAP;
		else if (pick < 78)
			c.cmd = CMD_WR_STATUS;
		else if (pick < 86)
			c.cmd = CMD_WR_BASE;
		else if (pick < 95)
			c.cmd = CMD_RAISE_IPI;
		else
			c.cmd = 3'($urandom_range(7, 5));
		// re-enable traps after an entry so interrupts keep coming
		if (!allow_halt && !sb.st.traps_enabled && ((c.cmd == CMD_SYNC_TRAP &&
				c.trap_num != 8'd0) || (c.cmd == CMD_TICK && $urandom_range(1) == 0))) begin
			c.cmd = CMD_WR_STATUS;
			c.wr_enable_traps = 1'b1;
			c.wr_window = 5'($urandom_range(WINDOWS - 1));
		end
		return c;
	endfunction

	task automatic run_random(input int n, input int snd_idle, input int rcv_stall,
			input bit press, input logic [31:0] period);
		write_timer(period);
		idle_pct = snd_idle;
		stall_pct <= rcv_stall;
		pressure_on <= press;
		repeat (n) send(rand_cmd(1'b0));
		req_valid <= 1'b0;
	endtask

	// directed sequence: extremes, every command and the corner cases
	task automatic run_directed();
		tie_in_t c;
		write_timer(32'd4);
		c = quiet_cmd(CMD_WR_BASE);
		c.wr_base = '1;
		send(c);
		// tick with traps off: level only latched
		c = quiet_cmd(CMD_TICK);
		c.ext_level = 4'd15;
		c.cycle_count = 32'd1;
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_level = 4'd15;
		send(c);
		// level 15 beats proc level 15, window wraps down from 0
		c = quiet_cmd(CMD_TICK);
		c.pc = '1;
		c.npc = '1;
		c.cycle_count = 32'd1;
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_window = 5'(WINDOWS - 1);
		send(c);
		// trap number zero is ignored
		c = quiet_cmd(CMD_SYNC_TRAP);
		send(c);
		c = quiet_cmd(CMD_SYNC_TRAP);
		c.trap_num = 8'hFF;
		c.pc = '0;
		c.npc = '0;
		send(c);
		// window writes out of range are dropped
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_window = 5'd31;
		send(c);
		c.wr_window = 5'(WINDOWS);
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_window = 5'd1;
		send(c);
		// inter-processor request taken and cleared
		send(quiet_cmd(CMD_RAISE_IPI));
		c = quiet_cmd(CMD_TICK);
		c.cycle_count = 32'd1;
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_level = 4'd9;
		send(c);
		// timer fires on a period boundary
		c = quiet_cmd(CMD_TICK);
		c.cycle_count = 32'd8;
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_window = 5'd3;
		send(c);
		// mailbox interrupt acknowledges the message
		c = quiet_cmd(CMD_TICK);
		c.mailbox_valid = 1'b1;
		c.cycle_count = 32'd3;
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_level = 4'd7;
		c.wr_window = 5'd2;
		send(c);
		// mailbox trap without a message
		c = quiet_cmd(CMD_SYNC_TRAP);
		c.trap_num = TT_MAILBOX;
		send(c);
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_enable_traps = 1'b1;
		c.wr_level = 4'd12;
		c.wr_window = 5'd4;
		send(c);
		// levels below proc level stay pending
		c = quiet_cmd(CMD_TICK);
		c.ext_level = 4'd5;
		c.cycle_count = 32'd1;
		send(c);
		c.ext_level = 4'd0;
		c.mailbox_valid = 1'b1;
		send(c);
		// unused commands
		send(quiet_cmd(3'd5));
		send(quiet_cmd(3'd6));
		send(quiet_cmd(3'd7));
		c = quiet_cmd(CMD_WR_BASE);
		send(c);
		req_valid <= 1'b0;
	endtask

	// error mode: trap with traps off, then everything but a request is dropped
	task automatic run_error_mode();
		tie_in_t c;
		write_timer(32'd8);
		idle_pct = 32;
		stall_pct <= 32;
		pressure_on <= 1'b0;
		c = quiet_cmd(CMD_WR_STATUS);
		c.wr_window = 5'd5;
		send(c);
		c = quiet_cmd(CMD_SYNC_TRAP);
		c.trap_num = 8'h42;
		send(c);
		repeat (40) send(rand_cmd(1'b1));
		req_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(170, 0, 0, 1'b0, 32'd0);
		run_random(170, 61, 0, 1'b0, 32'd1);
		run_random(170, 0, 61, 1'b0, 32'hFFFF_FFFF);
		run_random(170, 32, 32, 1'b0, 32'h8000_0000);
		run_random(170, 0, 0, 1'b1, 32'd1 << $urandom_range(8, 3));
		run_random(170, 0, 0, 1'b0, 32'd16);
		run_error_mode();

		// drain, then allow for the pipeline
		while (sb.trap_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
